FILE: rtl/lsc_pkg.sv
package lsc_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = 5;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [SLOT_W-1:0]  slot_t;

  typedef struct packed {
    logic   valid;
    key_t   key;
    stamp_t stamp;
  } entry_t;

  // broadcast controls for the row of cells
  typedef struct packed {
    logic shift;
    logic clear;
    logic write;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESULT
  } state_t;

endpackage

FILE: rtl/lsc_req_if.sv
interface lsc_req_if;
  logic              valid;
  logic              ready;
  logic              op;
  lsc_pkg::key_t     key;
  lsc_pkg::stamp_t   now_time;

  modport source (output valid, op, key, now_time, input ready);
  modport sink   (input valid, op, key, now_time, output ready);
endinterface

FILE: rtl/lsc_rsp_if.sv
interface lsc_rsp_if;
  logic            valid;
  logic            ready;
  lsc_pkg::slot_t  slot;
  logic            hit;
  logic            evicted;

  modport source (output valid, slot, hit, evicted, input ready);
  modport sink   (input valid, slot, hit, evicted, output ready);
endinterface

FILE: rtl/lru_sample_cache_slot_manager.sv
// lru sample cache slot manager
//
// req channel (sink): op, key, now_time. op add looks the key up and either
// refreshes its stamp (hit), fills the first free slot, or replaces the
// oldest entry when all slots are used (evicted). op clear empties the cache.
// rsp channel (source): slot, hit, evicted; one item per request.
//
// the entries live in a ring of cells that rotates one place per cycle during
// a lookup, so the head cell shows entry k in scan cycle k. the scan always
// runs the full ring to bring every entry back home, then a write cycle
// updates the selected cell. an add passes through the scan, write and
// result states before rsp valid is set; a clear goes from idle straight
// to the result state. one request is worked on at a time; req ready is high
// only while idle, so no new request is taken until the last one is done.
// reset empties the cache and clears victim_slot; no clearing pass is needed.
// if rsp is stalled the finished item waits in the result state and the
// next request is held off until the output register is free for it.
module lru_sample_cache_slot_manager (
  input logic      clk,
  input logic      rst,
  lsc_req_if.sink  req,
  lsc_rsp_if.source rsp
);

  lsc_pkg::state_t    state, state_next;
  lsc_pkg::cell_ctl_t ctl;
  lsc_pkg::entry_t    ent [lsc_pkg::ENTRIES];
  logic [lsc_pkg::ENTRIES-1:0] sel;

  // latched request
  lsc_pkg::key_t   key;
  lsc_pkg::stamp_t now_time;

  // scan tracking
  lsc_pkg::idx_t   cnt;
  logic            stop;
  lsc_pkg::cnt_t   used;
  lsc_pkg::idx_t   oldest;
  lsc_pkg::stamp_t oldest_stamp;
  logic            found;
  lsc_pkg::idx_t   found_at;
  lsc_pkg::idx_t   victim_slot;

  // finished result
  lsc_pkg::idx_t   res_idx;
  logic            res_hit;
  logic            res_evicted;

  logic            req_acc;
  logic            rsp_free;
  logic            last;
  lsc_pkg::idx_t   wr_idx;
  logic            full;

  assign req_acc  = req.valid && req.ready;
  assign rsp_free = !rsp.valid || rsp.ready;
  assign last     = (cnt == lsc_pkg::idx_t'(lsc_pkg::ENTRIES - 1));
  assign full     = (used == lsc_pkg::cnt_t'(lsc_pkg::ENTRIES));

  // slot picked once the scan is done
  always_comb begin
    if (found) begin
      wr_idx = found_at;
    end else if (full) begin
      wr_idx = oldest;
    end else begin
      wr_idx = used[lsc_pkg::IDX_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < lsc_pkg::ENTRIES; i++) begin
      sel[i] = (wr_idx == lsc_pkg::idx_t'(i));
    end
  end

  // ring of entry cells, cell i takes from cell i+1, the last from cell 0
  for (genvar g = 0; g < lsc_pkg::ENTRIES; g++) begin : g_cell
    lsc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .sel      (sel[g]),
      .wr_key   (key),
      .wr_stamp (now_time),
      .nb       (ent[(g + 1) % lsc_pkg::ENTRIES]),
      .ent      (ent[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    req.ready  = 1'b0;
    unique case (state)
      lsc_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.op == lsc_pkg::OP_CLEAR) begin
            ctl.clear  = 1'b1;
            state_next = lsc_pkg::ST_RESULT;
          end else begin
            state_next = lsc_pkg::ST_SCAN;
          end
        end
      end
      lsc_pkg::ST_SCAN: begin
        ctl.shift = 1'b1;
        if (last) begin
          state_next = lsc_pkg::ST_WRITE;
        end
      end
      lsc_pkg::ST_WRITE: begin
        ctl.write  = 1'b1;
        state_next = lsc_pkg::ST_RESULT;
      end
      lsc_pkg::ST_RESULT: begin
        if (rsp_free) begin
          state_next = lsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lsc_pkg::ST_IDLE;
      end
    endcase
  end

  // request latch and scan tracking
  always_ff @(posedge clk) begin
    if (req_acc) begin
      key          <= req.key;
      now_time     <= req.now_time;
      cnt          <= '0;
      stop         <= 1'b0;
      used         <= lsc_pkg::cnt_t'(lsc_pkg::ENTRIES);
      oldest       <= '0;
      oldest_stamp <= ent[0].stamp;
      found        <= 1'b0;
      found_at     <= '0;
    end else if (state == lsc_pkg::ST_SCAN) begin
      cnt <= cnt + 1'b1;
      if (!stop) begin
        if (ent[0].valid) begin
          if (cnt == '0 || ent[0].stamp < oldest_stamp) begin
            oldest       <= cnt;
            oldest_stamp <= ent[0].stamp;
          end
          if (!found && ent[0].key == key) begin
            found    <= 1'b1;
            found_at <= cnt;
          end
        end else begin
          // contiguous fill: first empty slot ends the used range
          stop <= 1'b1;
          used <= lsc_pkg::cnt_t'(cnt);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      victim_slot <= '0;
    end else if (state == lsc_pkg::ST_WRITE) begin
      victim_slot <= oldest;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc && req.op == lsc_pkg::OP_CLEAR) begin
      res_idx     <= '0;
      res_hit     <= 1'b0;
      res_evicted <= 1'b0;
    end else if (state == lsc_pkg::ST_WRITE) begin
      res_idx     <= found ? found_at : (full ? oldest : used[lsc_pkg::IDX_W-1:0]);
      res_hit     <= found;
      res_evicted <= !found && full;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == lsc_pkg::ST_RESULT && rsp_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lsc_pkg::ST_RESULT && rsp_free) begin
      rsp.slot    <= (!res_hit && res_evicted) ? lsc_pkg::slot_t'(victim_slot)
                                               : lsc_pkg::slot_t'(res_idx);
      rsp.hit     <= res_hit;
      rsp.evicted <= res_evicted;
    end
  end

endmodule

FILE: rtl/lsc_cell.sv
module lsc_cell (
  input  logic               clk,
  input  logic               rst,
  input  lsc_pkg::cell_ctl_t ctl,
  input  logic               sel,
  input  lsc_pkg::key_t      wr_key,
  input  lsc_pkg::stamp_t    wr_stamp,
  input  lsc_pkg::entry_t    nb,
  output lsc_pkg::entry_t    ent
);

  logic            valid;
  lsc_pkg::key_t   key;
  lsc_pkg::stamp_t stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= nb.valid;
    end else if (ctl.write && sel) begin
      valid <= 1'b1;
    end
  end

  // payload rotates with the ring or takes the broadcast write
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key   <= nb.key;
      stamp <= nb.stamp;
    end else if (ctl.write && sel) begin
      key   <= wr_key;
      stamp <= wr_stamp;
    end
  end

  assign ent.valid = valid;
  assign ent.key   = key;
  assign ent.stamp = stamp;

endmodule

FILE: tb/sv/lru_sample_cache_slot_manager_tb.sv
module lru_sample_cache_slot_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // total cycles of the run, counted from the start, before it is declared hung
  localparam int unsigned CYCLE_LIMIT = 400_000;
  // idle tail after the last result, so that a stray result can still be seen
  localparam int unsigned TAIL_CYCLES = lsc_pkg::ENTRIES + 16;
  localparam int unsigned KEY_POOL_SIZE = 40;
  localparam int unsigned RANDOM_ITEMS = 1030;

  // one request item as the driver presents it
  typedef struct {
    logic            op;
    lsc_pkg::key_t   key;
    lsc_pkg::stamp_t now_time;
    bit              wait_drain;  // hold this item back until every result is in
  } lookup_req_t;

  // one response item
  typedef struct packed {
    lsc_pkg::slot_t slot;
    logic           hit;
    logic           evicted;
  } slot_result_t;

  logic clk;
  logic rst;

  lsc_req_if req_ch ();
  lsc_rsp_if rsp_ch ();

  lru_sample_cache_slot_manager u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the cache, updated as each request is accepted
  logic            shadow_valid [lsc_pkg::ENTRIES];
  lsc_pkg::key_t   shadow_key   [lsc_pkg::ENTRIES];
  lsc_pkg::stamp_t shadow_stamp [lsc_pkg::ENTRIES];
  int unsigned shadow_victim;

  lookup_req_t  lookup_reqs_pending [$];
  slot_result_t slot_results_due [$];
  lookup_req_t  req_on_bus;

  int unsigned reqs_total;
  int unsigned reqs_accepted;
  int unsigned results_taken;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned cycle_count;

  lsc_pkg::key_t   key_pool [KEY_POOL_SIZE];
  lsc_pkg::stamp_t tick;

  // clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // reset held at the start of the run, released once
  initial begin
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // expected outcome of one request; also updates the shadow cache
  function automatic slot_result_t predict_slot_lookup(lookup_req_t item);
    slot_result_t    res;
    int unsigned     i;
    int unsigned     used;
    int unsigned     oldest;
    lsc_pkg::stamp_t oldest_stamp;
    bit              found;
    int unsigned     found_at;
    int unsigned     target;
    res = '0;
    if (item.op == lsc_pkg::OP_CLEAR) begin
      // valid bits and stamps drop, keys stay, victim keeps its value
      for (i = 0; i < lsc_pkg::ENTRIES; i++) begin
        shadow_valid[i] = 1'b0;
        shadow_stamp[i] = '0;
      end
      return res;
    end
    // walk the used entries from slot 0: oldest stamp (lowest index on a
    // tie, plain unsigned compare) and first key match
    oldest = 0;
    oldest_stamp = shadow_stamp[0];
    found = 1'b0;
    found_at = 0;
    used = 0;
    while (used < lsc_pkg::ENTRIES && shadow_valid[used]) begin
      if (shadow_stamp[used] < oldest_stamp) begin
        oldest_stamp = shadow_stamp[used];
        oldest = used;
      end
      if (!found && shadow_key[used] == item.key) begin
        found = 1'b1;
        found_at = used;
      end
      used++;
    end
    shadow_victim = oldest;
    if (found) begin
      target = found_at;
      shadow_stamp[target] = item.now_time;
      res.hit = 1'b1;
    end else begin
      if (used >= lsc_pkg::ENTRIES) begin
        target = shadow_victim;
        res.evicted = 1'b1;
      end else begin
        target = used;
      end
      shadow_key[target] = item.key;
      shadow_stamp[target] = item.now_time;
      shadow_valid[target] = 1'b1;
    end
    res.slot = lsc_pkg::slot_t'(target);
    return res;
  endfunction

  // idle percentage per side: sender 22 / receiver 59, then swapped, then none
  function automatic int unsigned idle_pct(bit sender_side);
    int unsigned phase;
    phase = (reqs_total == 0) ? 0 : (reqs_accepted * 3) / reqs_total;
    case (phase)
      0: begin
        return sender_side ? 22 : 59;
      end
      1: begin
        return sender_side ? 59 : 22;
      end
      default: begin
        return 0;
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint unsigned want,
                                 longint unsigned got);
    $display("mismatch on result %0d: %s expected %0h got %0h",
             results_checked, what, want, got);
    mismatches++;
  endtask

  task automatic queue_req(logic op, lsc_pkg::key_t key, lsc_pkg::stamp_t now_time,
                           bit wait_drain);
    lookup_req_t item;
    item.op = op;
    item.key = key;
    item.now_time = now_time;
    item.wait_drain = wait_drain;
    lookup_reqs_pending.push_back(item);
  endtask

  // driver: presents queued items, predicts each one at the edge it is taken
  always @(posedge clk) begin
    bit           fire;
    bit           send;
    slot_result_t due;
    int unsigned  i;
    if (rst) begin
      req_ch.valid    <= 1'b0;
      req_ch.op       <= lsc_pkg::OP_ADD;
      req_ch.key      <= '0;
      req_ch.now_time <= '0;
      shadow_victim = 0;
      for (i = 0; i < lsc_pkg::ENTRIES; i++) begin
        shadow_valid[i] = 1'b0;
        shadow_key[i] = '0;
        shadow_stamp[i] = '0;
      end
    end else begin
      fire = req_ch.valid && req_ch.ready;
      if (fire) begin
        due = predict_slot_lookup(req_on_bus);
        slot_results_due.push_back(due);
        reqs_accepted <= reqs_accepted + 1;
      end
      if (!req_ch.valid || fire) begin
        send = 1'b0;
        if (lookup_reqs_pending.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          // a drain item waits until nothing is in flight; counters are
          // compared at their pre-edge values so the check is race free
          if (!lookup_reqs_pending[0].wait_drain ||
              (!fire && reqs_accepted == results_taken)) begin
            send = 1'b1;
          end
        end
        if (send) begin
          req_on_bus = lookup_reqs_pending.pop_front();
          req_ch.valid    <= 1'b1;
          req_ch.op       <= req_on_bus.op;
          req_ch.key      <= req_on_bus.key;
          req_ch.now_time <= req_on_bus.now_time;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, every taken result checked in order
  always @(posedge clk) begin
    slot_result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_taken <= results_taken + 1;
        if (slot_results_due.size() == 0) begin
          report_mismatch("result with nothing pending, slot", 0, rsp_ch.slot);
        end else begin
          want = slot_results_due.pop_front();
          if (rsp_ch.slot !== want.slot)
            report_mismatch("slot", want.slot, rsp_ch.slot);
          if (rsp_ch.hit !== want.hit)
            report_mismatch("hit", want.hit, rsp_ch.hit);
          if (rsp_ch.evicted !== want.evicted)
            report_mismatch("evicted", want.evicted, rsp_ch.evicted);
        end
        results_checked++;
      end
      rsp_ch.ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** lru_sample_cache_slot_manager: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned   n;
    int unsigned   roll;
    lsc_pkg::key_t k;
    logic          op;
    bit            drain;

    // directed part
    queue_req(lsc_pkg::OP_CLEAR, '1, '1, 1'b0);             // clear on an empty cache
    queue_req(lsc_pkg::OP_ADD, '0, '0, 1'b0);               // empty cache, lands in slot 0
    queue_req(lsc_pkg::OP_ADD, '1, '1, 1'b0);               // all-ones key and stamp
    queue_req(lsc_pkg::OP_ADD, '0, 32'd5, 1'b0);            // hit on slot 0
    queue_req(lsc_pkg::OP_ADD, 32'h8000_0001, 32'd5, 1'b0); // stamp tie with slot 0
    queue_req(lsc_pkg::OP_ADD, 32'h0000_0005, 32'hffff_fff0, 1'b0);
    queue_req(lsc_pkg::OP_ADD, '0, 32'd3, 1'b0);            // counter wrapped, stamp goes back
    queue_req(lsc_pkg::OP_ADD, 32'h7fff_ffff, 32'd3, 1'b0); // same stamp twice
    queue_req(lsc_pkg::OP_ADD, 32'h8000_0001, 32'h0000_0002, 1'b0);
    queue_req(lsc_pkg::OP_CLEAR, '0, '0, 1'b0);             // clear a partly used cache
    queue_req(lsc_pkg::OP_ADD, '1, 32'h10, 1'b0);           // old key still stored, but invalid
    queue_req(lsc_pkg::OP_ADD, '1, 32'h11, 1'b0);           // hit after clear
    queue_req(lsc_pkg::OP_ADD, '0, 32'h11, 1'b0);
    for (n = 0; n < 10; n++)
      queue_req(lsc_pkg::OP_ADD, $urandom, 32'h20 + n, 1'b0);
    queue_req(lsc_pkg::OP_ADD, '0, 32'h40, 1'b0);           // hit on slot 1, behind ten newer entries

    // random part: mostly a small key pool with a slowly rising clock so the
    // cache fills, hits and evicts; some fresh keys, clock jumps and clears
    for (n = 0; n < KEY_POOL_SIZE; n++)
      key_pool[n] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    tick = 32'h100;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      drain = (n == 0) || (n % 150 == 75);
      roll = $urandom_range(99);
      op = (roll < 1) ? lsc_pkg::OP_CLEAR : lsc_pkg::OP_ADD;
      k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL_SIZE - 1)]
                                    : lsc_pkg::key_t'($urandom);
      roll = $urandom_range(99);
      if (roll < 80)
        tick = tick + $urandom_range(3);
      else if (roll < 86)
        tick = '1 - $urandom_range(3);               // about to wrap
      else if (roll < 92)
        tick = $urandom_range(7);                    // just wrapped
      else
        tick = $urandom;
      queue_req(op, k, tick, drain);
    end
    reqs_total = lookup_reqs_pending.size();

    // wait for the stimulus to be taken and every result to come back
    while (lookup_reqs_pending.size() > 0 || req_ch.valid || slot_results_due.size() > 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (slot_results_due.size() > 0)
      report_mismatch("results never produced, count", 0, slot_results_due.size());

    if (mismatches == 0) begin
      $display("** lru_sample_cache_slot_manager: PASSED **");
    end else begin
      $display("** lru_sample_cache_slot_manager: FAILED **");
    end
    $finish;
  end

endmodule
